// ===== rtl/core/fnpll_pkg.sv =====
//------------------------------------------------------------------------------
// fnpll_pkg
// Shared types and constants for the fractional-N tune planner.
//------------------------------------------------------------------------------
`default_nettype none
package fnpll_pkg;

	localparam int unsigned FreqW  = 33;
	localparam int unsigned StepW  = 27;
	localparam int unsigned ModW   = 12;
	localparam int unsigned PfdW   = 28;
	localparam int unsigned CpW    = 4;
	localparam int unsigned UsW    = 20;
	localparam int unsigned PwrW   = 8;
	localparam int unsigned CfgW   = 33;
	localparam int unsigned CfgIdxW = 3;
	// widest dividend handled by the serial divider (pfd * us)
	localparam int unsigned DivW   = 48;
	localparam int unsigned DivCntW = 6;

	localparam logic [11:0] NMin   = 12'd16;
	localparam logic [11:0] NMax   = 12'd4091;
	localparam logic [11:0] DivSat = 12'd4095;
	localparam logic [DivW-1:0] UsPerS = 48'd1000000;
	localparam logic [2:0] MaxExp  = 3'd7;

	typedef enum logic [2:0] {
		CFG_STEP = 3'd0,
		CFG_MOD  = 3'd1,
		CFG_PFD  = 3'd2,
		CFG_CP   = 3'd3,
		CFG_VMIN = 3'd4,
		CFG_VMAX = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FREQ   = 2'd1,
		ST_NRANGE = 2'd2,
		ST_FLOCK  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXP, S_DSTEP, S_DN, S_GCD, S_DF, S_DM, S_MUL, S_DUS, S_DFL,
		S_ACT, S_OUT
	} fsm_t;

	typedef struct packed {
		logic           start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [DivW-1:0] quo;
		logic [DivW-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        shut_down;
		logic        integer_mode;
		logic [11:0] n_value;
		logic [11:0] frac_f;
		logic [11:0] frac_m;
		logic [2:0]  out_div_log2;
		logic [11:0] fastlock_div;
		logic [32:0] actual_hz;
		logic [2:0]  power_a_code;
		logic [2:0]  power_b_code;
	} result_t;

	function automatic logic [2:0] power_code(input logic signed [7:0] p);
		logic [2:0] c;
		if (p < -8'sd4)      c = 3'd0;
		else if (p >= 8'sd5) c = 3'd7;
		else if (p >= 8'sd2) c = 3'd6;
		else if (p >= -8'sd1) c = 3'd5;
		else                 c = 3'd4;
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fnpll_if.sv =====
//------------------------------------------------------------------------------
// fnpll channel interfaces
// Valid/ready channels for tune requests and plan results.
//------------------------------------------------------------------------------
`default_nettype none
interface fnpll_req_if;
	logic        valid;
	logic        ready;
	logic [32:0] target_hz;
	logic [19:0] fastlock_us;
	logic signed [7:0] power_a_dbm;
	logic signed [7:0] power_b_dbm;
	modport source (output valid, target_hz, fastlock_us, power_a_dbm, power_b_dbm,
		input ready);
	modport sink (input valid, target_hz, fastlock_us, power_a_dbm, power_b_dbm,
		output ready);
endinterface

interface fnpll_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        shut_down;
	logic        integer_mode;
	logic [11:0] n_value;
	logic [11:0] frac_f;
	logic [11:0] frac_m;
	logic [2:0]  out_div_log2;
	logic [11:0] fastlock_div;
	logic [32:0] actual_hz;
	logic [2:0]  power_a_code;
	logic [2:0]  power_b_code;
	modport source (output valid, status, shut_down, integer_mode, n_value, frac_f,
		frac_m, out_div_log2, fastlock_div, actual_hz, power_a_code, power_b_code,
		input ready);
	modport sink (input valid, status, shut_down, integer_mode, n_value, frac_f,
		frac_m, out_div_log2, fastlock_div, actual_hz, power_a_code, power_b_code,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fnpll_sdiv.sv =====
//------------------------------------------------------------------------------
// fnpll_sdiv
// Restoring bit-serial divider: one quotient bit per cycle over DivW bits.
//------------------------------------------------------------------------------
`default_nettype none
module fnpll_sdiv
	import fnpll_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);
	logic [DivW-1:0]    rem_q, quo_q, den_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q, done_q;
	logic [DivW:0]      trial;

	// shift in next dividend bit and try subtraction
	assign trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DivW]) rem_q <= trial[DivW-1:0];
			else              rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
			quo_q <= {quo_q[DivW-2:0], ~trial[DivW]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/frac_n_pll_tune_planner.sv =====
//------------------------------------------------------------------------------
// frac_n_pll_tune_planner
// Fractional-N tune planner: one plan per tune request.
//------------------------------------------------------------------------------
// Usage:
//   req   : sink channel carrying target_hz, fastlock_us and two power requests.
//   res   : source channel carrying status and the fractional-N plan.
//   cfg_* : write port for step, modulus, PFD, charge pump and VCO limits.
// One request is worked at a time. All divisions (steps, N, gcd, F/g, M/g,
// fast-lock) run on one shared bit-serial divider: start, 48 quotient bits,
// done. The multiplies are shift-add, one bit per cycle. Shutdown and range
// errors are answered in the cycle after the request is accepted; when the
// output divider exponent runs out, the error follows the S_EXP doublings.
// Integer mode skips gcd, F/g and M/g; a zero fastlock_us skips fast lock.
// Reset returns the configuration registers to their defaults and the
// sequencer to idle. The result is held in an output register until taken;
// a stalled receiver holds the block off from accepting the next request.
//------------------------------------------------------------------------------
`default_nettype none
module frac_n_pll_tune_planner
	import fnpll_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data,
	fnpll_req_if.sink               req,
	fnpll_res_if.source             res
);
	// configuration registers
	logic [StepW-1:0] step_q;
	logic [ModW-1:0]  mod_q;
	logic [PfdW-1:0]  pfd_q;
	logic [CpW-1:0]   cp_q;
	logic [FreqW-1:0] vmin_q, vmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 27'd100000;
			mod_q  <= 12'd1000;
			pfd_q  <= 28'd100000000;
			cp_q   <= '0;
			vmin_q <= 33'd3000000000;
			vmax_q <= 33'd6000000000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP: step_q <= cfg_data[StepW-1:0];
				CFG_MOD:  mod_q  <= cfg_data[ModW-1:0];
				CFG_PFD:  pfd_q  <= cfg_data[PfdW-1:0];
				CFG_CP:   cp_q   <= cfg_data[CpW-1:0];
				CFG_VMIN: vmin_q <= cfg_data;
				CFG_VMAX: vmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fsm_t state_q, state_d;
	div_req_t dreq;
	div_rsp_t drsp;
	fnpll_sdiv u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// working registers; freq keeps one extra bit for the last doubling
	logic [FreqW:0]   freq_q;
	logic [2:0]       exp_q;
	logic [19:0]      us_q;
	logic [7:0]       pa_q, pb_q;
	logic [DivW-1:0]  steps_q, n_q;
	logic [ModW-1:0]  f_q, m_q, ga_q, gb_q;
	logic             started_q, fnz_q;
	logic [DivW-1:0]  acc_q, mcand_q, mplier_q;
	logic [DivCntW-1:0] mcnt_q;
	result_t          res_q;
	logic             rvalid_q;

	logic [StepW-1:0] step_eff;
	logic [ModW-1:0]  mod_eff;
	assign step_eff = (step_q == '0) ? StepW'(1) : step_q;
	assign mod_eff  = (mod_q == '0) ? ModW'(1) : mod_q;

	logic accept, range_bad;
	assign req.ready = (state_q == S_IDLE) && !rvalid_q;
	assign accept    = req.valid && req.ready;
	assign range_bad = (req.target_hz > vmax_q) || (req.target_hz < (vmin_q >> 7));

	// result as loaded on an accepted request
	result_t res_init;
	always_comb begin
		res_init = '0;
		res_init.shut_down = (req.target_hz == '0);
		if (req.target_hz != '0 && range_bad) res_init.status = ST_FREQ;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept && req.target_hz != '0 && !range_bad) state_d = S_EXP;
			S_EXP:   if (freq_q >= {1'b0, vmin_q}) state_d = S_DSTEP;
				else if (exp_q == MaxExp) state_d = S_OUT;
			S_DSTEP: if (started_q && drsp.done) state_d = S_DN;
			S_DN:    if (started_q && drsp.done) begin
					if (drsp.quo < DivW'(NMin) || drsp.quo > DivW'(NMax)) state_d = S_OUT;
					else if (drsp.rem == '0) state_d = S_MUL;
					else state_d = S_GCD;
				end
			S_GCD:   if (gb_q == '0) state_d = S_DF;
			S_DF:    if (started_q && drsp.done) state_d = S_DM;
			S_DM:    if (started_q && drsp.done) state_d = S_MUL;
			S_MUL:   if (us_q != '0 && cp_q != '0) state_d = S_OUT;
				else if (mcnt_q == '0 && started_q)
					state_d = (us_q == '0) ? S_ACT : S_DUS;
			S_DUS:   if (started_q && drsp.done) state_d = S_DFL;
			S_DFL:   if (started_q && drsp.done) state_d = S_ACT;
			S_ACT:   if (mcnt_q == '0 && started_q) state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// divider requests
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = DivW'(1);
		case (state_q)
			S_DSTEP: begin
				dreq.num = DivW'(freq_q);
				dreq.den = DivW'(step_eff);
			end
			S_DN: begin
				dreq.num = steps_q;
				dreq.den = DivW'(mod_eff);
			end
			S_GCD: begin
				dreq.num = DivW'(ga_q);
				dreq.den = DivW'(gb_q);
			end
			S_DF: begin
				dreq.num = DivW'(f_q);
				dreq.den = DivW'(ga_q);
			end
			S_DM: begin
				dreq.num = DivW'(mod_eff);
				dreq.den = DivW'(ga_q);
			end
			S_DUS: begin
				dreq.num = acc_q;
				dreq.den = UsPerS;
			end
			S_DFL: begin
				dreq.num = acc_q;
				dreq.den = DivW'(m_q);
			end
			default: ;
		endcase
		if (!started_q && (state_q == S_DSTEP || state_q == S_DN || state_q == S_DF
			|| state_q == S_DM || state_q == S_DUS || state_q == S_DFL
			|| (state_q == S_GCD && gb_q != '0)))
			dreq.start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			rvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) started_q <= 1'b0;
			else if (state_q == S_GCD) started_q <= dreq.start ? 1'b1 : !drsp.done && started_q;
			else if (state_q == S_MUL || state_q == S_ACT) started_q <= 1'b1;
			else if (dreq.start) started_q <= 1'b1;
			if (res.valid && res.ready) rvalid_q <= 1'b0;
			if (accept && (req.target_hz == '0 || range_bad)) rvalid_q <= 1'b1;
			if (state_q == S_OUT) rvalid_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				freq_q <= {1'b0, req.target_hz};
				exp_q  <= '0;
				us_q   <= req.fastlock_us;
				pa_q   <= req.power_a_dbm;
				pb_q   <= req.power_b_dbm;
				res_q  <= res_init;
			end
			S_EXP: if (freq_q < {1'b0, vmin_q}) begin
				if (exp_q == MaxExp) res_q.status <= ST_FREQ;
				else begin
					freq_q <= {freq_q[FreqW-1:0], 1'b0};
					exp_q  <= exp_q + 1'b1;
				end
			end
			S_DSTEP: if (started_q && drsp.done) steps_q <= drsp.quo;
			S_DN: if (started_q && drsp.done) begin
				n_q   <= drsp.quo;
				f_q   <= drsp.rem[ModW-1:0];
				ga_q  <= drsp.rem[ModW-1:0];
				gb_q  <= mod_eff;
				m_q   <= mod_eff;
				fnz_q <= (drsp.rem != '0);
				if (drsp.quo < DivW'(NMin) || drsp.quo > DivW'(NMax))
					res_q.status <= ST_NRANGE;
			end
			S_GCD: if (started_q && drsp.done) begin
				ga_q <= gb_q;
				gb_q <= drsp.rem[ModW-1:0];
			end
			S_DF: if (started_q && drsp.done) f_q <= drsp.quo[ModW-1:0];
			S_DM: if (started_q && drsp.done) m_q <= drsp.quo[ModW-1:0];
			S_MUL: begin
				if (us_q != '0 && cp_q != '0) res_q.status <= ST_FLOCK;
				// pfd * us, shift-add one multiplier bit per cycle
				if (!started_q) begin
					acc_q    <= '0;
					mcand_q  <= DivW'(pfd_q);
					mplier_q <= DivW'(us_q);
					mcnt_q   <= DivCntW'(UsW - 1);
				end else begin
					if (mplier_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q  <= {mcand_q[DivW-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
					mcnt_q   <= mcnt_q - 1'b1;
				end
			end
			// pfd*us/1e6 goes back into the accumulator
			S_DUS: if (started_q && drsp.done) acc_q <= drsp.quo;
			S_DFL: if (started_q && drsp.done)
				res_q.fastlock_div <= (drsp.quo > DivW'(DivSat)) ? DivSat : drsp.quo[11:0];
			S_ACT: begin
				// steps * step, shift-add over the step bits
				if (!started_q) begin
					acc_q    <= '0;
					mcand_q  <= steps_q;
					mplier_q <= DivW'(step_eff);
					mcnt_q   <= DivCntW'(StepW - 1);
				end else begin
					if (mplier_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q  <= {mcand_q[DivW-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
					mcnt_q   <= mcnt_q - 1'b1;
				end
			end
			S_OUT: if (res_q.status == ST_OK) begin
				res_q.integer_mode <= !fnz_q;
				res_q.n_value      <= n_q[11:0];
				res_q.frac_f       <= f_q;
				res_q.frac_m       <= m_q;
				res_q.out_div_log2 <= exp_q;
				res_q.actual_hz    <= FreqW'(acc_q >> exp_q);
				res_q.power_a_code <= power_code(pa_q);
				res_q.power_b_code <= power_code(pb_q);
			end else begin
				res_q.fastlock_div <= '0;
			end
			default: ;
		endcase
	end

	// result register to the source channel
	assign res.valid        = rvalid_q;
	assign res.status       = res_q.status;
	assign res.shut_down    = res_q.shut_down;
	assign res.integer_mode = res_q.integer_mode;
	assign res.n_value      = res_q.n_value;
	assign res.frac_f       = res_q.frac_f;
	assign res.frac_m       = res_q.frac_m;
	assign res.out_div_log2 = res_q.out_div_log2;
	assign res.fastlock_div = res_q.fastlock_div;
	assign res.actual_hz    = res_q.actual_hz;
	assign res.power_a_code = res_q.power_a_code;
	assign res.power_b_code = res_q.power_b_code;
endmodule
`default_nettype wire

// ===== rtl/core/fnpll_chk.sv =====
//------------------------------------------------------------------------------
// fnpll_chk
// Port-level checks for the tune planner, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module fnpll_chk
	import fnpll_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  status,
	input wire logic        shut_down,
	input wire logic [11:0] n_value
);
	// one request in flight: no accept while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready) else $error("accept while result pending");
	// a result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");
	// shutdown carries no plan
	a_shut: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && shut_down |-> status == ST_OK && n_value == '0)
		else $error("shutdown with plan");
	// errors carry no N
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> n_value == '0) else $error("error with N");
endmodule

bind frac_n_pll_tune_planner fnpll_chk u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.res_valid(res.valid), .res_ready(res.ready), .status(res.status),
	.shut_down(res.shut_down), .n_value(res.n_value)
);
`default_nettype wire
